/* sv/aeth_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeth_pkg: shared constants, types and tables
// Widths, fixed-point constants, the controller-to-datapath command bundle
// and the CORDIC arctangent table for the accelerometer tilt heading block.
// ----------------------------------------------------------------------------
package aeth_pkg;

	// Algorithm settings
	localparam int CORDIC_ITERS = 16;
	localparam int ALPHA_BITS   = 16;
	localparam int TABLE_LEN    = 24;
	localparam int ITER_N       = (CORDIC_ITERS < TABLE_LEN) ? CORDIC_ITERS : TABLE_LEN;
	localparam int IDX_W        = $clog2(TABLE_LEN);

	// Field widths
	localparam int RAW_W   = 16;
	localparam int FILT_W  = 24;
	localparam int HEAD_W  = 16;
	localparam int ALPHA_W = 16;
	localparam int IN_W    = ((3 * RAW_W + 7) / 8) * 8;
	localparam int OUT_W   = ((3 * FILT_W + HEAD_W + 7) / 8) * 8;

	// Filter arithmetic
	localparam int RAW_SHIFT = 8;
	localparam int DIFF_W    = FILT_W + 1;
	localparam int PROD_W    = ALPHA_W + 1 + DIFF_W;
	localparam int SH_W      = PROD_W - ALPHA_BITS;
	localparam int SUM_W     = SH_W + 1;
	localparam logic signed [SUM_W-1:0] FILT_MAX = SUM_W'((1 << (FILT_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] FILT_MIN = -SUM_W'(1 << (FILT_W - 1));
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(9830);

	// CORDIC arithmetic
	localparam int PRE_SHIFT = 24;
	localparam int CX_W      = FILT_W + PRE_SHIFT + 4;
	localparam int Z_W       = 26;
	localparam int ATAN_W    = 22;
	localparam int RND_SHIFT = 8;
	localparam int RZ_W      = Z_W - RND_SHIFT;
	localparam logic signed [Z_W-1:0]  QUARTER_TURN = Z_W'(2949120);
	localparam logic signed [Z_W-1:0]  ROUND_HALF   = Z_W'(1 << (RND_SHIFT - 1));
	localparam logic signed [RZ_W-1:0] HEAD_MAX     = RZ_W'(23040);

	// Axis select codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic             load_in;
		logic             mul;
		logic             add;
		logic             init;
		logic             iter;
		logic             load_out;
		logic [1:0]       axis;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	// atan(2^-i) in 1/32768 degree
	function automatic logic [ATAN_W-1:0] atan_lut(input logic [IDX_W-1:0] i);
		logic [ATAN_W-1:0] v;
		case (i)
			5'd0:    v = ATAN_W'(1474560);
			5'd1:    v = ATAN_W'(870484);
			5'd2:    v = ATAN_W'(459940);
			5'd3:    v = ATAN_W'(233473);
			5'd4:    v = ATAN_W'(117189);
			5'd5:    v = ATAN_W'(58652);
			5'd6:    v = ATAN_W'(29333);
			5'd7:    v = ATAN_W'(14667);
			5'd8:    v = ATAN_W'(7334);
			5'd9:    v = ATAN_W'(3667);
			5'd10:   v = ATAN_W'(1833);
			5'd11:   v = ATAN_W'(917);
			5'd12:   v = ATAN_W'(458);
			5'd13:   v = ATAN_W'(229);
			5'd14:   v = ATAN_W'(115);
			5'd15:   v = ATAN_W'(57);
			5'd16:   v = ATAN_W'(29);
			5'd17:   v = ATAN_W'(14);
			5'd18:   v = ATAN_W'(7);
			5'd19:   v = ATAN_W'(4);
			5'd20:   v = ATAN_W'(2);
			5'd21:   v = ATAN_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* sv/aeth_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeth_ctrl: sequencing controller
// Walks one sample through the three filter updates, the CORDIC setup, the
// CORDIC iterations and the result load; owns the stream handshakes.
// ----------------------------------------------------------------------------
module aeth_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire           m_tready,
	output aeth_pkg::cmd_t cmd
);
	import aeth_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_ADD  = 7'b0000100,
		ST_INIT = 7'b0001000,
		ST_ITER = 7'b0010000,
		ST_OUT  = 7'b0100000,
		ST_SPARE = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [1:0]       axis_q;
	logic [IDX_W-1:0] idx_q;
	logic             m_tvalid_q;
	logic             out_free;

	// output register can take a result this cycle
	assign out_free = !m_tvalid_q || m_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.axis     = axis_q;
		cmd.idx      = idx_q;
		cmd.load_in  = s_tvalid && (state_q == ST_IDLE);
		cmd.mul      = (state_q == ST_MUL);
		cmd.add      = (state_q == ST_ADD);
		cmd.init     = (state_q == ST_INIT);
		cmd.iter     = (state_q == ST_ITER);
		cmd.load_out = (state_q == ST_OUT) && out_free;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= AXIS_X;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MUL;
						axis_q  <= AXIS_X;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (axis_q == AXIS_Z) begin
						state_q <= ST_INIT;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_MUL;
					end
				end
				ST_INIT: begin
					idx_q   <= '0;
					state_q <= ST_ITER;
				end
				ST_ITER: begin
					if (idx_q == IDX_W'(ITER_N - 1)) begin
						state_q <= ST_OUT;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* sv/aeth_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeth_dp: filter and heading datapath
// Shared multiplier for the three moving averages, a vectoring CORDIC with
// one micro-rotation per cycle, heading rounding and the output register.
// ----------------------------------------------------------------------------
module aeth_dp (
	input  wire                        clk,
	input  wire                        arst_n,
	input  aeth_pkg::cmd_t             cmd,
	input  wire                        cfg_we,
	input  wire [aeth_pkg::ALPHA_W-1:0] cfg_wdata,
	input  wire [aeth_pkg::IN_W-1:0]   in_data,
	output logic [aeth_pkg::OUT_W-1:0] out_data
);
	import aeth_pkg::*;

	logic [ALPHA_W-1:0]             alpha_q;
	logic signed [RAW_W-1:0]        raw_q [3];
	logic signed [FILT_W-1:0]       avg_q [3];
	logic signed [PROD_W-1:0]       prod_s1;

	logic signed [RAW_W-1:0]        raw_sel;
	logic signed [FILT_W-1:0]       avg_sel;
	logic signed [DIFF_W-1:0]       tgt_w;
	logic signed [DIFF_W-1:0]       diff_w;
	logic signed [PROD_W-1:0]       prod_w;
	logic signed [SH_W-1:0]         sh_w;
	logic signed [SUM_W-1:0]        sum_w;
	logic signed [FILT_W-1:0]       next_w;

	logic signed [CX_W-1:0]         x_q, y_q;
	logic signed [Z_W-1:0]          z_q;
	logic                           zero_q;
	logic signed [CX_W-1:0]         fx_w, fy_w, xs_w, ys_w;
	logic signed [Z_W-1:0]          atan_w;
	logic signed [Z_W-1:0]          zr_w;
	logic signed [RZ_W-1:0]         r_w;
	logic signed [HEAD_W-1:0]       head_w;

	logic signed [FILT_W-1:0]       fx_q, fy_q, fz_q;
	logic signed [HEAD_W-1:0]       head_q;

	// smoothing factor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (cfg_we) begin
			alpha_q <= cfg_wdata;
		end
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			raw_q[0] <= in_data[RAW_W-1:0];
			raw_q[1] <= in_data[2*RAW_W-1:RAW_W];
			raw_q[2] <= in_data[3*RAW_W-1:2*RAW_W];
		end
	end

	// filter step: diff and product, one axis per pass
	assign raw_sel = raw_q[cmd.axis];
	assign avg_sel = avg_q[cmd.axis];
	assign tgt_w   = {{(DIFF_W-RAW_W-RAW_SHIFT){raw_sel[RAW_W-1]}}, raw_sel,
		{RAW_SHIFT{1'b0}}};
	assign diff_w  = tgt_w - {{(DIFF_W-FILT_W){avg_sel[FILT_W-1]}}, avg_sel};
	assign prod_w  = $signed({1'b0, alpha_q}) * diff_w;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= prod_w;
		end
	end

	// filter step: scale, accumulate, saturate
	assign sh_w  = SH_W'(prod_s1 >>> ALPHA_BITS);
	assign sum_w = {{(SUM_W-FILT_W){avg_sel[FILT_W-1]}}, avg_sel}
		+ {{(SUM_W-SH_W){sh_w[SH_W-1]}}, sh_w};

	always_comb begin
		if (sum_w > FILT_MAX) begin
			next_w = FILT_W'(FILT_MAX);
		end else if (sum_w < FILT_MIN) begin
			next_w = FILT_W'(FILT_MIN);
		end else begin
			next_w = FILT_W'(sum_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q[0] <= '0;
			avg_q[1] <= '0;
			avg_q[2] <= '0;
		end else if (cmd.add) begin
			avg_q[cmd.axis] <= next_w;
		end
	end

	// CORDIC operands scaled up
	assign fx_w = {{(CX_W-FILT_W-PRE_SHIFT){avg_q[0][FILT_W-1]}}, avg_q[0],
		{PRE_SHIFT{1'b0}}};
	assign fy_w = {{(CX_W-FILT_W-PRE_SHIFT){avg_q[1][FILT_W-1]}}, avg_q[1],
		{PRE_SHIFT{1'b0}}};

	// micro-rotation terms
	assign xs_w   = x_q >>> cmd.idx;
	assign ys_w   = y_q >>> cmd.idx;
	assign atan_w = {{(Z_W-ATAN_W){1'b0}}, atan_lut(cmd.idx)};

	// CORDIC vectoring, left half-plane turned by a quarter first
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			zero_q <= (avg_q[0] == '0) && (avg_q[1] == '0);
			if (!avg_q[0][FILT_W-1]) begin
				x_q <= fx_w;
				y_q <= fy_w;
				z_q <= '0;
			end else if (!avg_q[1][FILT_W-1]) begin
				x_q <= fy_w;
				y_q <= -fx_w;
				z_q <= QUARTER_TURN;
			end else begin
				x_q <= -fy_w;
				y_q <= fx_w;
				z_q <= -QUARTER_TURN;
			end
		end else if (cmd.iter) begin
			if (!y_q[CX_W-1]) begin
				x_q <= x_q + ys_w;
				y_q <= y_q - xs_w;
				z_q <= z_q + atan_w;
			end else begin
				x_q <= x_q - ys_w;
				y_q <= y_q + xs_w;
				z_q <= z_q - atan_w;
			end
		end
	end

	// round to 1/128 degree and clamp
	assign zr_w = z_q + ROUND_HALF;
	assign r_w  = zr_w[Z_W-1:RND_SHIFT];

	always_comb begin
		if (zero_q) begin
			head_w = '0;
		end else if (r_w > HEAD_MAX) begin
			head_w = HEAD_W'(HEAD_MAX);
		end else if (r_w < -HEAD_MAX) begin
			head_w = HEAD_W'(-HEAD_MAX);
		end else begin
			head_w = HEAD_W'(r_w);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			fx_q   <= avg_q[0];
			fy_q   <= avg_q[1];
			fz_q   <= avg_q[2];
			head_q <= head_w;
		end
	end

	assign out_data = {head_q, fz_q, fy_q, fx_q};

endmodule
`default_nettype wire

/* sv/accel_ema_tilt_heading.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sequence from the accepting edge to m_tvalid: three filter updates (a multiply
// state and an add state each, on one shared multiplier), one CORDIC setup, 16 CORDIC
// steps and one result load, which waits while the output register is full. One
// sample is worked at a time; a new sample is taken while the last result still waits.
// Reset (arst_n low, asynchronous): averages cleared, alpha = 9830, idle.
// ----------------------------------------------------------------------------
// accel_ema_tilt_heading: accelerometer smoothing and tilt heading
// Per-axis exponential moving average of raw samples and the atan2 heading
// of the filtered x and y axes.
// ----------------------------------------------------------------------------
module accel_ema_tilt_heading (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [aeth_pkg::ALPHA_W-1:0]  cfg_wdata,   // alpha
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire [aeth_pkg::IN_W-1:0]     s_tdata,     // raw_x, raw_y, raw_z
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [aeth_pkg::OUT_W-1:0]   m_tdata      // filt_x, filt_y, filt_z, heading
);
	import aeth_pkg::*;

	cmd_t cmd;

	// sequencing
	aeth_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// arithmetic
	aeth_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire

/* sv/aeth_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aeth_chk: port-level checker
// Watches the stream ports of the tilt heading block over time.
// ----------------------------------------------------------------------------
module aeth_chk (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	input  wire                        s_tready,
	input  wire                        m_tvalid,
	input  wire                        m_tready,
	input  wire [aeth_pkg::OUT_W-1:0]  m_tdata
);
	import aeth_pkg::*;

	logic signed [FILT_W-1:0] fx, fy;
	logic signed [HEAD_W-1:0] hd;

	assign fx = m_tdata[FILT_W-1:0];
	assign fy = m_tdata[2*FILT_W-1:FILT_W];
	assign hd = m_tdata[3*FILT_W+HEAD_W-1:3*FILT_W];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one sample in flight: ready drops after each transaction
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second sample taken while busy");

	// heading stays within half a turn
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (hd <= HEAD_W'(23040)) && (hd >= -HEAD_W'(23040)))
		else $error("heading out of range");

	// zero vector gives zero heading
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (fx == '0) && (fy == '0) |-> (hd == '0))
		else $error("nonzero heading for zero vector");

	// a fresh result comes with the block idle again
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result raised while busy");

endmodule

bind accel_ema_tilt_heading aeth_chk u_aeth_chk (.*);
`default_nettype wire
